>>> hw/rtl/decc_pkg.sv
`default_nettype none
package decc_pkg;

  localparam int unsigned DEF_TICK_MS = 100;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_START  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_CRUISE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_ZONE   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_TEMP    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TEMP    = 3'd4;

  localparam logic [1:0] MODE_DIS    = 2'd0;
  localparam logic [1:0] MODE_EN     = 2'd1;
  localparam logic [1:0] MODE_CRUISE = 2'd2;

  // throttle law: dead band, limit, divide by 9 as multiply and shift
  localparam logic [10:0] DEAD_BAND   = 11'd100;
  localparam logic [13:0] THR_OFFSET  = 14'd996;
  localparam logic [14:0] DIV9_RECIP  = 15'd14564;
  localparam int unsigned DIV9_SHIFT  = 17;
  localparam logic [11:0] THR_LIMIT   = 12'd1000;

  localparam logic [15:0] RST_HOLD_START  = 16'd3000;
  localparam logic [15:0] RST_HOLD_CRUISE = 16'd3000;
  localparam logic [9:0]  RST_HOLD_ZONE   = 10'd500;
  localparam logic signed [15:0] RST_MIN_TEMP = -16'sd40;
  localparam logic signed [15:0] RST_MAX_TEMP = 16'sd85;

  typedef struct packed {
    logic [15:0]        hold_to_start_ms;
    logic [15:0]        hold_to_cruise_ms;
    logic [9:0]         hold_zone;
    logic signed [15:0] min_temp;
    logic signed [15:0] max_temp;
  } cfg_t;

  typedef struct packed {
    logic signed [10:0] joystick_pos;
    logic               btn_fwd;
    logic               btn_back;
    logic signed [15:0] temperature;
  } item_t;

endpackage
`default_nettype wire

>>> hw/rtl/decc_throttle.sv
`default_nettype none
module decc_throttle import decc_pkg::*; (
  input  wire logic signed [10:0] joystick_pos,
  output logic signed [10:0]      throttle
);

  logic        neg;
  logic [10:0] mag;
  logic        beyond;
  logic [13:0] num;
  logic [28:0] prod;
  logic [11:0] quo;
  logic [10:0] clipped;

  always_comb begin
    neg     = joystick_pos[10];
    mag     = neg ? 11'(-joystick_pos) : 11'(joystick_pos);
    beyond  = mag > DEAD_BAND;
    num     = ({3'b0, mag} << 3) + ({3'b0, mag} << 1) - THR_OFFSET;
    prod    = 29'(num) * 29'(DIV9_RECIP);
    quo     = prod[DIV9_SHIFT +: 12];
    clipped = (quo > THR_LIMIT) ? THR_LIMIT[10:0] : quo[10:0];
    if (!beyond) begin
      throttle = '0;
    end else if (neg) begin
      throttle = -$signed(clipped);
    end else begin
      throttle = $signed(clipped);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/decc_mode.sv
`default_nettype none
module decc_mode import decc_pkg::*; #(
  parameter int unsigned TICK_MS = DEF_TICK_MS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire item_t              item,
  input  wire logic signed [10:0] throttle,
  input  wire cfg_t               cfg,
  output logic                    motor_enabled,
  output logic signed [10:0]      motor_throttle,
  output logic [1:0]              drive_mode
);

  typedef enum logic [1:0] {
    DIS    = MODE_DIS,
    EN     = MODE_EN,
    CRUISE = MODE_CRUISE
  } mode_t;

  mode_t              mode, mode_next;
  logic               buttons_held, buttons_held_next;
  logic               toggle_allowed, toggle_allowed_next;
  logic [15:0]        start_hold_ms, start_hold_ms_next;
  logic [15:0]        cruise_hold_ms, cruise_hold_ms_next;
  logic signed [10:0] cruise_level, cruise_level_next;
  logic               joystick_exit_armed, joystick_exit_armed_next;
  logic [1:0]         latched_buttons, latched_buttons_next;
  logic signed [10:0] result;
  logic signed [10:0] zone, zone_neg;
  logic               in_zone;

  function automatic logic [15:0] sat_add(input logic [15:0] a);
    logic [16:0] s;
    s = {1'b0, a} + 17'(TICK_MS);
    return s[16] ? 16'hffff : s[15:0];
  endfunction

  always_comb begin
    mode_next                = mode;
    buttons_held_next        = buttons_held;
    toggle_allowed_next      = toggle_allowed;
    start_hold_ms_next       = start_hold_ms;
    cruise_hold_ms_next      = cruise_hold_ms;
    cruise_level_next        = cruise_level;
    joystick_exit_armed_next = joystick_exit_armed;
    latched_buttons_next     = latched_buttons;
    result                   = '0;
    zone                     = $signed({1'b0, cfg.hold_zone});
    zone_neg                 = -zone;
    in_zone = (item.joystick_pos <= 0 && item.joystick_pos > zone_neg) ||
              (item.joystick_pos >= 0 && item.joystick_pos < zone);

    // start/stop
    if (mode_next != CRUISE) begin
      if (item.btn_fwd && item.btn_back) begin
        buttons_held_next = 1'b1;
      end else begin
        buttons_held_next   = 1'b0;
        toggle_allowed_next = 1'b1;
        start_hold_ms_next  = '0;
      end
      if (buttons_held_next && toggle_allowed_next) begin
        start_hold_ms_next = sat_add(start_hold_ms_next);
        if (start_hold_ms_next >= cfg.hold_to_start_ms) begin
          mode_next           = (mode_next == EN) ? DIS : EN;
          start_hold_ms_next  = '0;
          toggle_allowed_next = 1'b0;
        end
      end
    end

    // cruise entry and exit
    if (mode_next == EN) begin
      if ((throttle > zone && item.btn_back) || (throttle < zone_neg && item.btn_fwd)) begin
        cruise_hold_ms_next = sat_add(cruise_hold_ms);
        if (cruise_hold_ms_next >= cfg.hold_to_cruise_ms) begin
          mode_next                = CRUISE;
          cruise_level_next        = throttle;
          cruise_hold_ms_next      = '0;
          joystick_exit_armed_next = 1'b0;
          latched_buttons_next     = {item.btn_back, item.btn_fwd};
        end
      end else begin
        cruise_hold_ms_next = '0;
      end
    end else if (mode_next == CRUISE) begin
      if (in_zone) begin
        joystick_exit_armed_next = 1'b1;
      end else if (joystick_exit_armed) begin
        mode_next = EN;
      end
      if (item.btn_fwd != latched_buttons[0] || item.btn_back != latched_buttons[1]) begin
        mode_next = EN;
      end
    end

    if (item.temperature < cfg.min_temp || item.temperature > cfg.max_temp) begin
      mode_next = DIS;
    end

    case (mode_next)
      EN:      result = throttle;
      CRUISE:  result = cruise_level_next;
      default: mode_next = DIS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                <= DIS;
      buttons_held        <= 1'b0;
      toggle_allowed      <= 1'b1;
      start_hold_ms       <= '0;
      cruise_hold_ms      <= '0;
      cruise_level        <= '0;
      joystick_exit_armed <= 1'b1;
      latched_buttons     <= '0;
    end else if (advance) begin
      mode                <= mode_next;
      buttons_held        <= buttons_held_next;
      toggle_allowed      <= toggle_allowed_next;
      start_hold_ms       <= start_hold_ms_next;
      cruise_hold_ms      <= cruise_hold_ms_next;
      cruise_level        <= cruise_level_next;
      joystick_exit_armed <= joystick_exit_armed_next;
      latched_buttons     <= latched_buttons_next;
    end
    if (advance) begin
      motor_enabled  <= (mode_next == EN) || (mode_next == CRUISE);
      motor_throttle <= result;
      drive_mode     <= mode_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/drive_enable_cruise_controller_core.sv
// Drive enable and cruise controller. Each input word is one control tick of
// TICK_MS milliseconds; each yields exactly one result word with the mode after
// the tick, the enable flag and the throttle command. One word is accepted every
// clock cycle unless a low out_ready stalls the result register; a word is held
// in the input register, and when it advances the throttle multiplier and mode
// update load the result register. Configuration writes are
// taken at any time but must only be issued while no word is in flight.
`default_nettype none
module drive_enable_cruise_controller_core import decc_pkg::*; #(
  parameter int unsigned TICK_MS = DEF_TICK_MS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic signed [10:0]     joystick_pos,
  input  wire logic                   btn_fwd,
  input  wire logic                   btn_back,
  input  wire logic signed [15:0]     temperature,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        motor_enabled,
  output logic signed [10:0]          motor_throttle,
  output logic [1:0]                  drive_mode
);

  cfg_t               cfg;
  item_t              s1_item;
  logic               s1_valid;
  logic               s1_advance;
  logic signed [10:0] throttle;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_to_start_ms  <= RST_HOLD_START;
      cfg.hold_to_cruise_ms <= RST_HOLD_CRUISE;
      cfg.hold_zone         <= RST_HOLD_ZONE;
      cfg.min_temp          <= RST_MIN_TEMP;
      cfg.max_temp          <= RST_MAX_TEMP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HOLD_START:  cfg.hold_to_start_ms  <= cfg_data;
        CFG_HOLD_CRUISE: cfg.hold_to_cruise_ms <= cfg_data;
        CFG_HOLD_ZONE:   cfg.hold_zone         <= cfg_data[9:0];
        CFG_MIN_TEMP:    cfg.min_temp          <= $signed(cfg_data);
        CFG_MAX_TEMP:    cfg.max_temp          <= $signed(cfg_data);
        default:         ;
      endcase
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_item.joystick_pos <= joystick_pos;
      s1_item.btn_fwd      <= btn_fwd;
      s1_item.btn_back     <= btn_back;
      s1_item.temperature  <= temperature;
    end
  end

  // result word register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  decc_throttle u_throttle (
    .joystick_pos (s1_item.joystick_pos),
    .throttle     (throttle)
  );

  decc_mode #(
    .TICK_MS (TICK_MS)
  ) u_mode (
    .clk            (clk),
    .rst            (rst),
    .advance        (s1_advance),
    .item           (s1_item),
    .throttle       (throttle),
    .cfg            (cfg),
    .motor_enabled  (motor_enabled),
    .motor_throttle (motor_throttle),
    .drive_mode     (drive_mode)
  );

  a_enable_matches_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (motor_enabled == (drive_mode != MODE_DIS)))
    else $error("enable flag disagrees with mode");

  a_disabled_zero_throttle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && drive_mode == MODE_DIS) |-> (motor_throttle == 11'sd0))
    else $error("throttle nonzero while disabled");

  a_overtemp_disables: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && (s1_item.temperature < cfg.min_temp ||
                    s1_item.temperature > cfg.max_temp)) |=> (drive_mode == MODE_DIS))
    else $error("temperature out of range did not disable");

  a_mode_code_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_mode == MODE_DIS || drive_mode == MODE_EN ||
                   drive_mode == MODE_CRUISE))
    else $error("unreachable mode code on output");

endmodule
`default_nettype wire
